// ----- hdl/hhve_pkg.sv -----
// Shared types, constants and name tables for the HTTP header value extractor.
// No dependencies; imported by hhve_ctrl, hhve_dp and http_header_value_extractor.
package hhve_pkg;

  // Default maximum stored value length in bytes.
  localparam int unsigned ValueMaxDefault = 64;
  // Counter width: holds VALUE_MAX + 1 (saturation mark) for VALUE_MAX up to 64.
  localparam int unsigned CntW = 7;
  localparam int unsigned ColW = 4;
  localparam logic [ColW-1:0] ColSat = 4'd15;

  // Header name lengths, colon included.
  localparam logic [ColW-1:0] EtagNameLen = 4'd5;
  localparam logic [ColW-1:0] ModNameLen  = 4'd14;

  // Special bytes.
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  // Which header the current line belongs to.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ETAG = 2'd1,
    KIND_MOD  = 2'd2
  } kind_e;

  // Source code reported with each result.
  typedef enum logic [1:0] {
    SRC_ETAG = 2'd0,
    SRC_MOD  = 2'd1,
    SRC_NONE = 2'd2
  } src_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_SHOW = 2'd2
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic byte_en;  // an input byte transfer happens this cycle
    logic rd_en;    // read value stores at the emit index
    logic idx_inc;  // advance emit index
    logic clear;    // return to reset state after the run
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last;     // current result is the final one of the run
  } sts_t;

  // "etag:" by column.
  function automatic logic [7:0] etag_char(input logic [ColW-1:0] col);
    logic [7:0] ch;
    unique case (col)
      4'd0:    ch = 8'h65; // e
      4'd1:    ch = 8'h74; // t
      4'd2:    ch = 8'h61; // a
      4'd3:    ch = 8'h67; // g
      4'd4:    ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "last-modified:" by column.
  function automatic logic [7:0] mod_char(input logic [ColW-1:0] col);
    logic [7:0] ch;
    unique case (col)
      4'd0:    ch = 8'h6C; // l
      4'd1:    ch = 8'h61; // a
      4'd2:    ch = 8'h73; // s
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h2D; // -
      4'd5:    ch = 8'h6D; // m
      4'd6:    ch = 8'h6F; // o
      4'd7:    ch = 8'h64; // d
      4'd8:    ch = 8'h69; // i
      4'd9:    ch = 8'h66; // f
      4'd10:   ch = 8'h69; // i
      4'd11:   ch = 8'h65; // e
      4'd12:   ch = 8'h64; // d
      4'd13:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/hhve_ctrl.sv -----
// Controller FSM: takes input bytes, then sequences value reads and result transfers.
// Depends on hhve_pkg.
module hhve_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          end_of_body_i,
  input  logic          out_ready_i,
  input  hhve_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output hhve_pkg::cmd_t cmd_o
);
  import hhve_pkg::*;

  state_e state_q, state_d;
  logic   in_xfer, out_xfer;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && end_of_body_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_xfer) state_d = sts_i.last ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.byte_en = in_valid_i;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_SHOW: begin
        out_valid_o   = 1'b1;
        cmd_o.idx_inc = out_ready_i & ~sts_i.last;
        cmd_o.clear   = out_ready_i & sts_i.last;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/hhve_dp.sv -----
// Datapath: line parser, header value stores, committed lengths and result fields.
// Depends on hhve_pkg.
module hhve_dp #(
  parameter int unsigned VALUE_MAX = hhve_pkg::ValueMaxDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hhve_pkg::cmd_t cmd_i,
  input  logic [7:0]    byte_value_i,
  input  logic          end_of_body_i,
  output hhve_pkg::sts_t sts_o,
  output logic [7:0]    value_byte_o,
  output logic          byte_valid_o,
  output logic [1:0]    source_o,
  output logic          truncated_o,
  output logic          last_result_o
);
  import hhve_pkg::*;

  localparam int unsigned AW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
  localparam logic [CntW-1:0] VMax = CntW'(VALUE_MAX);
  localparam logic [CntW-1:0] CSat = CntW'(VALUE_MAX + 1);

  // Line parse state
  logic [ColW-1:0] col_q, col_d;
  logic            etag_ok_q, etag_ok_d;
  logic            mod_ok_q, mod_ok_d;
  kind_e           kind_q, kind_d;
  logic            skip_q, skip_d;
  logic            crp_q, crp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] end_q, end_d;
  // Committed values
  logic [CntW-1:0] etag_len_q, etag_len_d;
  logic            etag_seen_q, etag_seen_d;
  logic            etag_cut_q, etag_cut_d;
  logic [CntW-1:0] mod_len_q, mod_len_d;
  logic            mod_seen_q, mod_seen_d;
  logic            mod_cut_q, mod_cut_d;
  // Emit index
  logic [CntW-1:0] idx_q, idx_d;

  // Stores
  logic [7:0] etag_mem [VALUE_MAX];
  logic [7:0] mod_mem  [VALUE_MAX];
  logic [7:0] etag_rd_q, mod_rd_q;

  logic            is_lf, blank, is_cr;
  logic [7:0]      lc;
  logic            we;
  logic            commit;
  kind_e           c_kind;
  logic [CntW-1:0] c_end, c_len;
  logic            c_cut;
  logic [CntW-1:0] cnt_inc;

  assign is_lf   = (byte_value_i == ChLf);
  assign is_cr   = (byte_value_i == ChCr);
  assign blank   = (byte_value_i == ChSpace) || (byte_value_i == ChTab);
  assign lc      = (byte_value_i >= ChUpA && byte_value_i <= ChUpZ) ?
                   (byte_value_i | 8'h20) : byte_value_i;
  assign cnt_inc = (cnt_q >= CSat) ? CSat : cnt_q + CntW'(1);

  // Store write: value byte not skipped as leading blank, within capacity
  assign we = cmd_i.byte_en && !is_lf && (kind_q != KIND_NONE) &&
              !(skip_q && blank) && (cnt_q < VMax);

  // Byte processing and line commit
  always_comb begin
    col_d       = col_q;
    etag_ok_d   = etag_ok_q;
    mod_ok_d    = mod_ok_q;
    kind_d      = kind_q;
    skip_d      = skip_q;
    crp_d       = crp_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    etag_len_d  = etag_len_q;
    etag_seen_d = etag_seen_q;
    etag_cut_d  = etag_cut_q;
    mod_len_d   = mod_len_q;
    mod_seen_d  = mod_seen_q;
    mod_cut_d   = mod_cut_q;
    idx_d       = idx_q;
    commit      = 1'b0;
    c_kind      = kind_q;
    c_end       = end_q;
    c_len       = '0;
    c_cut       = 1'b0;

    if (cmd_i.byte_en) begin
      if (is_lf) begin
        commit = 1'b1;
      end else if (kind_q != KIND_NONE) begin
        // value byte
        if (!(skip_q && blank)) begin
          skip_d = 1'b0;
          if (is_cr) begin
            crp_d = 1'b1;
          end else begin
            if (crp_q) begin
              end_d = cnt_q;
              crp_d = 1'b0;
            end
            if (!blank) end_d = cnt_inc;
          end
          cnt_d = cnt_inc;
        end
        commit = end_of_body_i;
        c_end  = end_d;
      end else begin
        // header name byte
        if (!(col_q < EtagNameLen && lc == etag_char(col_q))) etag_ok_d = 1'b0;
        if (!(col_q < ModNameLen && lc == mod_char(col_q)))   mod_ok_d  = 1'b0;
        if (col_q < ColSat) col_d = col_q + ColW'(1);
        if (etag_ok_d && col_d == EtagNameLen) begin
          kind_d = KIND_ETAG;
        end else if (mod_ok_d && col_d == ModNameLen) begin
          kind_d = KIND_MOD;
        end
        commit = end_of_body_i;
        c_kind = kind_d;
      end
    end

    // Commit the finished line to the matching header and start a fresh line
    c_cut = (c_end > VMax);
    c_len = c_cut ? VMax : c_end;
    if (commit) begin
      if (c_kind == KIND_ETAG) begin
        etag_len_d  = c_len;
        etag_cut_d  = c_cut;
        etag_seen_d = 1'b1;
      end else if (c_kind == KIND_MOD) begin
        mod_len_d  = c_len;
        mod_cut_d  = c_cut;
        mod_seen_d = 1'b1;
      end
      col_d     = '0;
      etag_ok_d = 1'b1;
      mod_ok_d  = 1'b1;
      kind_d    = KIND_NONE;
      skip_d    = 1'b1;
      crp_d     = 1'b0;
      cnt_d     = '0;
      end_d     = '0;
    end

    if (cmd_i.idx_inc) idx_d = idx_q + CntW'(1);

    // End of run: back to reset values
    if (cmd_i.clear) begin
      col_d       = '0;
      etag_ok_d   = 1'b1;
      mod_ok_d    = 1'b1;
      kind_d      = KIND_NONE;
      skip_d      = 1'b1;
      crp_d       = 1'b0;
      cnt_d       = '0;
      end_d       = '0;
      etag_len_d  = '0;
      etag_seen_d = 1'b0;
      etag_cut_d  = 1'b0;
      mod_len_d   = '0;
      mod_seen_d  = 1'b0;
      mod_cut_d   = 1'b0;
      idx_d       = '0;
    end
  end

  // Control and length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      etag_ok_q   <= 1'b1;
      mod_ok_q    <= 1'b1;
      kind_q      <= KIND_NONE;
      skip_q      <= 1'b1;
      crp_q       <= 1'b0;
      cnt_q       <= '0;
      end_q       <= '0;
      etag_len_q  <= '0;
      etag_seen_q <= 1'b0;
      etag_cut_q  <= 1'b0;
      mod_len_q   <= '0;
      mod_seen_q  <= 1'b0;
      mod_cut_q   <= 1'b0;
      idx_q       <= '0;
    end else begin
      col_q       <= col_d;
      etag_ok_q   <= etag_ok_d;
      mod_ok_q    <= mod_ok_d;
      kind_q      <= kind_d;
      skip_q      <= skip_d;
      crp_q       <= crp_d;
      cnt_q       <= cnt_d;
      end_q       <= end_d;
      etag_len_q  <= etag_len_d;
      etag_seen_q <= etag_seen_d;
      etag_cut_q  <= etag_cut_d;
      mod_len_q   <= mod_len_d;
      mod_seen_q  <= mod_seen_d;
      mod_cut_q   <= mod_cut_d;
      idx_q       <= idx_d;
    end
  end

  // ETag value store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we && kind_q == KIND_ETAG) etag_mem[cnt_q[AW-1:0]] <= byte_value_i;
    if (cmd_i.rd_en) etag_rd_q <= etag_mem[idx_q[AW-1:0]];
  end

  // Last-Modified value store
  always_ff @(posedge clk_i) begin
    if (we && kind_q == KIND_MOD) mod_mem[cnt_q[AW-1:0]] <= byte_value_i;
    if (cmd_i.rd_en) mod_rd_q <= mod_mem[idx_q[AW-1:0]];
  end

  // Result selection: ETag wins over Last-Modified
  src_e            src;
  logic [CntW-1:0] sel_len;
  logic            sel_cut;
  logic            len_zero;

  always_comb begin
    priority if (etag_seen_q) begin
      src     = SRC_ETAG;
      sel_len = etag_len_q;
      sel_cut = etag_cut_q;
    end else if (mod_seen_q) begin
      src     = SRC_MOD;
      sel_len = mod_len_q;
      sel_cut = mod_cut_q;
    end else begin
      src     = SRC_NONE;
      sel_len = '0;
      sel_cut = 1'b0;
    end
  end

  assign len_zero      = (sel_len == '0);
  assign sts_o.last    = len_zero || (idx_q + CntW'(1) == sel_len);
  assign value_byte_o  = len_zero ? 8'h00 : ((src == SRC_ETAG) ? etag_rd_q : mod_rd_q);
  assign byte_valid_o  = ~len_zero;
  assign source_o      = src;
  assign truncated_o   = sel_cut;
  assign last_result_o = sts_o.last;

endmodule

// ----- hdl/http_header_value_extractor.sv -----
// HTTP header value extractor: ETag / Last-Modified value from a response byte stream.
// Timing: header bytes are taken one per cycle while the controller is idle. After
//   the end_of_body transfer, each result is read from the value store (ST_READ),
//   then presented (ST_SHOW) until it transfers. Input is held off from end_of_body
//   until the last result transfers; the next read waits for each transfer.
// Reset (rst_ni low, asynchronous): parser and lengths cleared; stores need no clearing.
// Depends on hhve_pkg, hhve_ctrl, hhve_dp.
module http_header_value_extractor #(
  parameter int unsigned VALUE_MAX = hhve_pkg::ValueMaxDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       end_of_body_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] value_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] source_o,
  output logic       truncated_o,
  output logic       last_result_o
);
  import hhve_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hhve_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_body_i (end_of_body_i),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd)
  );

  hhve_dp #(
    .VALUE_MAX (VALUE_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .byte_value_i  (byte_value_i),
    .end_of_body_i (end_of_body_i),
    .sts_o         (sts),
    .value_byte_o  (value_byte_o),
    .byte_valid_o  (byte_valid_o),
    .source_o      (source_o),
    .truncated_o   (truncated_o),
    .last_result_o (last_result_o)
  );

endmodule
